### rtl/ptwf_pkg.sv
package ptwf_pkg;

    localparam int HISTORY_DEPTH_DEF = 12;

    localparam int PRESS_W = 17;
    localparam int HPA_W   = 11;
    localparam int HUM_W   = 14;
    localparam int TIME_W  = 32;
    localparam int TEMP_W  = 15;
    localparam int HOUR_W  = 5;
    localparam int DROP_W  = 6;
    localparam int ICE_T_W = 13;
    localparam int FC_W    = 4;
    localparam int TF_W    = 3;

    // APB map: register i at byte address 4*i
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_UPDATE_INTERVAL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STORM_DROP      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RAIN_DROP       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HUMIDITY_RISE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ICE_TEMPERATURE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ICE_HUMIDITY    = 3'd5;

    localparam logic [TIME_W-1:0]  UPDATE_INTERVAL_RST = 32'd900000;
    localparam logic [DROP_W-1:0]  STORM_DROP_RST      = 6'd3;
    localparam logic [DROP_W-1:0]  RAIN_DROP_RST       = 6'd1;
    localparam logic [HUM_W-1:0]   HUMIDITY_RISE_RST   = 14'd500;
    localparam logic [ICE_T_W-1:0] ICE_TEMPERATURE_RST = 13'd200;
    localparam logic [HUM_W-1:0]   ICE_HUMIDITY_RST    = 14'd8000;

    // floor(p / 100) = (p * HPA_RECIP) >> HPA_SHIFT, exact for 17-bit p
    localparam int RECIP_W   = 18;
    localparam int HPA_SHIFT = 24;
    localparam logic [RECIP_W-1:0] HPA_RECIP = 18'd167773;

    localparam logic [HUM_W-1:0] HUM_NIGHT_LEVEL = 14'd8800;
    localparam logic [HUM_W-1:0] HUM_DAY_LEVEL   = 14'd7800;
    localparam logic [HUM_W-1:0] HUM_EARLY_RAIN  = 14'd8000;
    localparam logic [HUM_W-1:0] HUM_SOON_LEVEL  = 14'd6500;
    localparam int HUM_TREND_STEP = 100;
    localparam logic [HPA_W-1:0] LOW_GUARD_HPA = 11'd1008;
    localparam logic [HPA_W-1:0] SOON_HPA      = 11'd1005;

    localparam logic [FC_W-1:0] FC_UNKNOWN      = 4'd0;
    localparam logic [FC_W-1:0] FC_GOOD         = 4'd1;
    localparam logic [FC_W-1:0] FC_SETTLED      = 4'd2;
    localparam logic [FC_W-1:0] FC_FINE         = 4'd3;
    localparam logic [FC_W-1:0] FC_IMPROVING    = 4'd4;
    localparam logic [FC_W-1:0] FC_CHANGEABLE   = 4'd5;
    localparam logic [FC_W-1:0] FC_UNSETTLED    = 4'd6;
    localparam logic [FC_W-1:0] FC_RAIN         = 4'd7;
    localparam logic [FC_W-1:0] FC_STORMY       = 4'd8;
    localparam logic [FC_W-1:0] FC_SUDDEN_RAIN  = 4'd9;
    localparam logic [FC_W-1:0] FC_SUDDEN_STORM = 4'd10;
    localparam logic [FC_W-1:0] FC_SNOW         = 4'd11;

    localparam logic [TF_W-1:0] TF_UNKNOWN  = 3'd0;
    localparam logic [TF_W-1:0] TF_IMMINENT = 3'd1;
    localparam logic [TF_W-1:0] TF_SOON     = 3'd2;
    localparam logic [TF_W-1:0] TF_LATER    = 3'd3;
    localparam logic [TF_W-1:0] TF_STABLE   = 3'd4;

    typedef struct packed {
        logic [HPA_W-1:0] hpa;
        logic [HUM_W-1:0] hum;
    } entry_t;

    typedef struct packed {
        logic alarm;    // storm drop, or rain drop with humidity rise
        logic storm;
        logic rain;
        logic p_neg;
        logic p_pos;
        logic h_up;     // humidity rose by the trend step or more
        logic h_down;   // humidity fell by the trend step or more
    } diff_flags_t;

endpackage

### rtl/ptwf_reading_if.sv
interface ptwf_reading_if import ptwf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [PRESS_W-1:0]       pressure_pa;
    logic [TIME_W-1:0]        reading_time;
    logic                     winter;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic [HOUR_W-1:0]        hour_of_day;

    modport source (
        output valid, pressure_pa, reading_time, winter, temperature, humidity,
               hour_of_day,
        input  ready
    );
    modport sink (
        input  valid, pressure_pa, reading_time, winter, temperature, humidity,
               hour_of_day,
        output ready
    );
endinterface

### rtl/ptwf_result_if.sv
interface ptwf_result_if import ptwf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [FC_W-1:0] forecast;
    logic [TF_W-1:0] timeframe;
    logic            radar_alert;

    modport source (
        output valid, forecast, timeframe, radar_alert,
        input  ready
    );
    modport sink (
        input  valid, forecast, timeframe, radar_alert,
        output ready
    );
endinterface

### rtl/ptwf_diff_unit.sv
module ptwf_diff_unit import ptwf_pkg::*; (
    input  entry_t            older,
    input  entry_t            newer,
    input  logic [DROP_W-1:0] storm_drop,
    input  logic [DROP_W-1:0] rain_drop,
    input  logic [HUM_W-1:0]  humidity_rise,
    output diff_flags_t       flags
);

    localparam int PD_W = HPA_W + 2;
    localparam int HD_W = HUM_W + 2;

    logic signed [PD_W-1:0] pd;
    logic signed [PD_W-1:0] storm_lim;
    logic signed [PD_W-1:0] rain_lim;
    logic signed [HD_W-1:0] hd;
    logic signed [HD_W-1:0] rise_lim;

    assign pd = $signed({2'b00, newer.hpa}) - $signed({2'b00, older.hpa});
    assign hd = $signed({2'b00, newer.hum}) - $signed({2'b00, older.hum});
    assign storm_lim = -$signed({{(PD_W-DROP_W){1'b0}}, storm_drop});
    assign rain_lim  = -$signed({{(PD_W-DROP_W){1'b0}}, rain_drop});
    assign rise_lim  = $signed({2'b00, humidity_rise});

    always_comb
    begin
        flags.storm  = (pd <= storm_lim);
        flags.rain   = (pd <= rain_lim) && (hd >= rise_lim);
        flags.alarm  = flags.storm || flags.rain;
        flags.p_neg  = (pd < 0);
        flags.p_pos  = (pd > 0);
        flags.h_up   = (hd >= HD_W'(HUM_TREND_STEP));
        flags.h_down = (hd <= -HD_W'(HUM_TREND_STEP));
    end

endmodule

### rtl/pressure_trend_weather_forecaster_top.sv
// Each word passes S_PREP, S_WRITE and S_RD_TREND; with two or more valid entries
// it goes on through S_RD_SHORT, S_EVAL and S_SCAN (history pairs until one
// raises the radar alert or all are checked), then S_DONE; with fewer, S_DONE.
// reading.ready is high only in idle; no new word is taken before S_DONE is left.
// Reset (rst_n, async, active low): history empty, registers at defaults.
module pressure_trend_weather_forecaster_top import ptwf_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ptwf_reading_if.sink          reading,
    ptwf_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // History sits in a circular buffer. wp_reg is the slot for the next
    // word; logical index k (0 oldest slot, DEPTH-1 newest) maps to
    // physical slot (wp + k) mod DEPTH. Only valid entries are ever used,
    // so the store needs no clearing.
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int VC_W  = $clog2(HISTORY_DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_P = (PTR_W+1)'(HISTORY_DEPTH);
    localparam logic [VC_W-1:0]  DEPTH_V = VC_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] TOP_L   = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [PTR_W-1:0] PEN_L   = PTR_W'(HISTORY_DEPTH - 2);
    localparam logic [PTR_W-1:0] TOP2_L  = PTR_W'(HISTORY_DEPTH - 3);
    localparam int PROD_W = PRESS_W + RECIP_W;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PREP     = 3'd1;  // hPa conversion, shift decision
    localparam logic [2:0] S_WRITE    = 3'd2;  // history write
    localparam logic [2:0] S_RD_TREND = 3'd3;  // read oldest valid and newest
    localparam logic [2:0] S_RD_SHORT = 3'd4;  // latch long trend, read top-2/top
    localparam logic [2:0] S_EVAL     = 3'd5;  // forecast and timeframe
    localparam logic [2:0] S_SCAN     = 3'd6;  // one history pair a cycle
    localparam logic [2:0] S_DONE     = 3'd7;  // hand over to output register

    // ---- configuration ----
    logic [TIME_W-1:0]  update_interval_reg;
    logic [DROP_W-1:0]  storm_drop_reg;
    logic [DROP_W-1:0]  rain_drop_reg;
    logic [HUM_W-1:0]   humidity_rise_reg;
    logic [ICE_T_W-1:0] ice_temperature_reg;
    logic [HUM_W-1:0]   ice_humidity_reg;
    logic               cfg_we;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_interval_reg <= UPDATE_INTERVAL_RST;
            storm_drop_reg      <= STORM_DROP_RST;
            rain_drop_reg       <= RAIN_DROP_RST;
            humidity_rise_reg   <= HUMIDITY_RISE_RST;
            ice_temperature_reg <= ICE_TEMPERATURE_RST;
            ice_humidity_reg    <= ICE_HUMIDITY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_UPDATE_INTERVAL: update_interval_reg <= pwdata;
                REG_STORM_DROP:      storm_drop_reg      <= pwdata[DROP_W-1:0];
                REG_RAIN_DROP:       rain_drop_reg       <= pwdata[DROP_W-1:0];
                REG_HUMIDITY_RISE:   humidity_rise_reg   <= pwdata[HUM_W-1:0];
                REG_ICE_TEMPERATURE: ice_temperature_reg <= pwdata[ICE_T_W-1:0];
                REG_ICE_HUMIDITY:    ice_humidity_reg    <= pwdata[HUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_UPDATE_INTERVAL: prdata = update_interval_reg;
            REG_STORM_DROP:      prdata = {{(APB_DATA_W-DROP_W){1'b0}}, storm_drop_reg};
            REG_RAIN_DROP:       prdata = {{(APB_DATA_W-DROP_W){1'b0}}, rain_drop_reg};
            REG_HUMIDITY_RISE:   prdata = {{(APB_DATA_W-HUM_W){1'b0}}, humidity_rise_reg};
            REG_ICE_TEMPERATURE: prdata = {{(APB_DATA_W-ICE_T_W){ice_temperature_reg[ICE_T_W-1]}},
                                           ice_temperature_reg};
            REG_ICE_HUMIDITY:    prdata = {{(APB_DATA_W-HUM_W){1'b0}}, ice_humidity_reg};
            default:             prdata = '0;
        endcase
    end

    // ---- sequencer and datapath registers ----
    logic [2:0]               state_reg, state_next;
    logic [PRESS_W-1:0]       press_reg;
    logic [TIME_W-1:0]        time_reg;
    logic                     winter_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [HUM_W-1:0]         hum_reg;
    logic [HOUR_W-1:0]        hour_reg;
    logic [HPA_W-1:0]         hpa_reg, hpa_next;
    logic                     shift_reg, shift_next;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [VC_W-1:0]   vc_reg, vc_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;

    logic [PTR_W-1:0] li_reg, li_next;
    logic [PTR_W-1:0] lj_reg, lj_next;
    logic [PTR_W-1:0] rd_a_l, rd_b_l;

    // long-term trend flags and newest entry
    logic             tr_neg_reg, tr_neg_next;
    logic             tr_pos_reg, tr_pos_next;
    logic             th_up_reg, th_up_next;
    logic             th_down_reg, th_down_next;
    logic [HPA_W-1:0] newest_hpa_reg, newest_hpa_next;

    logic [FC_W-1:0] fc_reg, fc_next;
    logic [TF_W-1:0] tf_reg, tf_next;
    logic            radar_reg, radar_next;

    logic            out_valid_reg;
    logic [FC_W-1:0] out_fc_reg;
    logic [TF_W-1:0] out_tf_reg;
    logic            out_radar_reg;
    logic            out_load;

    // history store
    entry_t mem [HISTORY_DEPTH];
    entry_t mem_a_q, mem_b_q;
    logic   mem_we;

    entry_t      cur_entry;
    entry_t      op_a, op_b;
    diff_flags_t dflags;

    logic [PROD_W-1:0]  hpa_prod;
    logic [VC_W-1:0]    old_v;
    logic [PTR_W-1:0]   old_l;
    logic               hist_full;
    logic               night;
    logic               cold;
    logic [HUM_W-1:0]   hum_level;
    logic signed [HPA_W+1:0] hpa_adj;
    logic [FC_W-1:0]    zam_fc;
    logic [FC_W-1:0]    guard_fc;
    logic [FC_W-1:0]    eval_fc;
    logic [TF_W-1:0]    eval_tf;

    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] wp,
                                              input logic [PTR_W-1:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, wp} + {1'b0, k};
        if (s >= DEPTH_P)
            s = s - DEPTH_P;
        return s[PTR_W-1:0];
    endfunction

    assign reading.ready = (state_reg == S_IDLE);
    assign cur_entry     = '{hpa: hpa_reg, hum: hum_reg};
    assign hpa_prod      = PROD_W'(press_reg) * PROD_W'(HPA_RECIP);
    assign old_v         = DEPTH_V - vc_reg;
    assign old_l         = old_v[PTR_W-1:0];
    assign hist_full     = (vc_reg == DEPTH_V);

    ptwf_diff_unit u_diff (
        .older         (op_a),
        .newer         (op_b),
        .storm_drop    (storm_drop_reg),
        .rain_drop     (rain_drop_reg),
        .humidity_rise (humidity_rise_reg),
        .flags         (dflags)
    );

    // forecast pieces, evaluated in S_EVAL
    assign night     = (hour_reg >= HOUR_W'(21)) || (hour_reg <= HOUR_W'(7));
    assign hum_level = night ? HUM_NIGHT_LEVEL : HUM_DAY_LEVEL;
    assign cold      = temp_reg <= $signed({{(TEMP_W-ICE_T_W){ice_temperature_reg[ICE_T_W-1]}},
                                             ice_temperature_reg});
    // seasonal offset: may go below zero, lands in the lowest band then
    assign hpa_adj   = $signed({2'b00, hpa_reg}) +
                       (winter_reg ? -(HPA_W+2)'(2) : (HPA_W+2)'(2));

    always_comb
    begin
        priority if (tr_pos_reg)
        begin
            priority if (hpa_adj >= (HPA_W+2)'(1020))      zam_fc = FC_GOOD;
            else if (hpa_adj >= (HPA_W+2)'(1000))          zam_fc = FC_SETTLED;
            else                                           zam_fc = FC_FINE;
        end
        else if (tr_neg_reg)
        begin
            priority if (hpa_adj >= (HPA_W+2)'(1010))      zam_fc = FC_UNSETTLED;
            else if (hpa_adj >= (HPA_W+2)'(990))           zam_fc = FC_RAIN;
            else                                           zam_fc = FC_STORMY;
        end
        else
        begin
            priority if (hpa_adj >= (HPA_W+2)'(1016))      zam_fc = FC_FINE;
            else if (hpa_adj >= (HPA_W+2)'(1002))          zam_fc = FC_IMPROVING;
            else                                           zam_fc = FC_CHANGEABLE;
        end

        // low-pressure guard turns fair bands into changeable
        guard_fc = zam_fc;
        if (hpa_reg <= LOW_GUARD_HPA && zam_fc >= FC_GOOD && zam_fc <= FC_IMPROVING)
            guard_fc = FC_CHANGEABLE;
        if (guard_fc == FC_RAIN && cold && hum_reg >= ice_humidity_reg)
            guard_fc = FC_SNOW;

        priority if (hum_reg >= hum_level)
            eval_fc = cold ? FC_SNOW : FC_RAIN;
        else if (dflags.storm)
            eval_fc = FC_SUDDEN_STORM;
        else if (dflags.rain)
            eval_fc = FC_SUDDEN_RAIN;
        else
            eval_fc = guard_fc;

        priority if (vc_reg < VC_W'(3))
            eval_tf = TF_UNKNOWN;
        else if (tr_neg_reg)
            eval_tf = th_up_reg ? TF_IMMINENT : TF_LATER;
        else if (tr_pos_reg)
            eval_tf = th_down_reg ? TF_IMMINENT : TF_LATER;
        else if (newest_hpa_reg < SOON_HPA && (th_up_reg || hum_reg >= HUM_SOON_LEVEL))
            eval_tf = TF_SOON;
        else
            eval_tf = TF_STABLE;
    end

    always_comb
    begin
        state_next      = state_reg;
        hpa_next        = hpa_reg;
        shift_next      = shift_reg;
        wp_next         = wp_reg;
        vc_next         = vc_reg;
        last_time_next  = last_time_reg;
        li_next         = li_reg;
        lj_next         = lj_reg;
        tr_neg_next     = tr_neg_reg;
        tr_pos_next     = tr_pos_reg;
        th_up_next      = th_up_reg;
        th_down_next    = th_down_reg;
        newest_hpa_next = newest_hpa_reg;
        fc_next         = fc_reg;
        tf_next         = tf_reg;
        radar_next      = radar_reg;
        rd_a_l          = li_reg;
        rd_b_l          = lj_reg;
        op_a            = mem_a_q;
        op_b            = mem_b_q;
        mem_we          = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (reading.valid)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                hpa_next   = hpa_prod[HPA_SHIFT +: HPA_W];
                shift_next = (vc_reg == '0) ||
                             ((time_reg - last_time_reg) >= update_interval_reg);
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (shift_reg)
                begin
                    mem_we         = 1'b1;
                    wp_next        = (wp_reg == TOP_L) ? '0 : wp_reg + PTR_W'(1);
                    last_time_next = time_reg;
                    if (vc_reg != DEPTH_V)
                        vc_next = vc_reg + VC_W'(1);
                end
                state_next = S_RD_TREND;
            end
            S_RD_TREND:
            begin
                rd_a_l = old_l;
                rd_b_l = TOP_L;
                if (vc_reg < VC_W'(2))
                begin
                    fc_next    = (hum_reg >= HUM_EARLY_RAIN) ? FC_RAIN : FC_UNKNOWN;
                    tf_next    = TF_UNKNOWN;
                    radar_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                    state_next = S_RD_SHORT;
            end
            S_RD_SHORT:
            begin
                // full: newest minus oldest; else current reading minus oldest
                op_b            = hist_full ? mem_b_q : cur_entry;
                tr_neg_next     = dflags.p_neg;
                tr_pos_next     = dflags.p_pos;
                th_up_next      = dflags.h_up;
                th_down_next    = dflags.h_down;
                newest_hpa_next = mem_b_q.hpa;
                rd_a_l          = TOP2_L;
                rd_b_l          = TOP_L;
                state_next      = S_EVAL;
            end
            S_EVAL:
            begin
                // under three entries the short-term changes count as zero
                if (vc_reg < VC_W'(3))
                begin
                    op_a = cur_entry;
                    op_b = cur_entry;
                end
                fc_next    = eval_fc;
                tf_next    = eval_tf;
                radar_next = 1'b0;
                li_next    = old_l;
                lj_next    = old_l + PTR_W'(1);
                rd_a_l     = old_l;
                rd_b_l     = old_l + PTR_W'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // data for pair (li, lj) is in mem_a_q / mem_b_q
                priority if (dflags.alarm)
                begin
                    radar_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (li_reg == PEN_L)
                    state_next = S_DONE;
                else
                begin
                    if (lj_reg == TOP_L)
                    begin
                        li_next = li_reg + PTR_W'(1);
                        lj_next = li_reg + PTR_W'(2);
                    end
                    else
                        lj_next = lj_reg + PTR_W'(1);
                    rd_a_l = li_next;
                    rd_b_l = lj_next;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= cur_entry;
        mem_a_q <= mem[phys(wp_reg, rd_a_l)];
        mem_b_q <= mem[phys(wp_reg, rd_b_l)];
    end

    // input word capture and payload
    always_ff @(posedge clk)
    begin
        if (reading.valid && reading.ready)
        begin
            press_reg  <= reading.pressure_pa;
            time_reg   <= reading.reading_time;
            winter_reg <= reading.winter;
            temp_reg   <= reading.temperature;
            hum_reg    <= reading.humidity;
            hour_reg   <= reading.hour_of_day;
        end
        hpa_reg        <= hpa_next;
        shift_reg      <= shift_next;
        li_reg         <= li_next;
        lj_reg         <= lj_next;
        tr_neg_reg     <= tr_neg_next;
        tr_pos_reg     <= tr_pos_next;
        th_up_reg      <= th_up_next;
        th_down_reg    <= th_down_next;
        newest_hpa_reg <= newest_hpa_next;
        fc_reg         <= fc_next;
        tf_reg         <= tf_next;
        radar_reg      <= radar_next;
        if (out_load)
        begin
            out_fc_reg    <= fc_reg;
            out_tf_reg    <= tf_reg;
            out_radar_reg <= radar_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            vc_reg        <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            vc_reg        <= vc_next;
            last_time_reg <= last_time_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.forecast    = out_fc_reg;
    assign result.timeframe   = out_tf_reg;
    assign result.radar_alert = out_radar_reg;

`ifndef SYNTHESIS
    // fill count saturates at the depth
    a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= DEPTH_V)
        else $error("history fill count above depth");

    // a radar alert needs at least one history pair
    a_radar_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.radar_alert |-> vc_reg >= VC_W'(2))
        else $error("radar alert with fewer than two entries");

    // one word in flight: no second accept straight after the first
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        reading.valid && reading.ready |=> !reading.ready)
        else $error("input accepted while busy");

    // scan pair ordering
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> li_reg < lj_reg && li_reg >= old_l)
        else $error("scan pair out of order");
`endif

endmodule

### sim/ptwf_tb_pkg.sv
`timescale 1ns / 100ps
package ptwf_tb_pkg;
    import ptwf_pkg::*;

    localparam int HISTORY = HISTORY_DEPTH_DEF;
    localparam int NEWEST  = HISTORY - 1;

    typedef struct packed {
        logic [PRESS_W-1:0]       pressure_pa;
        logic [TIME_W-1:0]        reading_time;
        logic                     winter;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
        logic [HOUR_W-1:0]        hour_of_day;
    } reading_t;

    typedef struct packed {
        logic [FC_W-1:0] forecast;
        logic [TF_W-1:0] timeframe;
        logic            radar_alert;
    } outlook_t;

    class forecast_scoreboard;
        logic [PRESS_W-1:0] press_hist [HISTORY];
        logic [HUM_W-1:0]   hum_hist [HISTORY];
        int unsigned        filled;
        logic [TIME_W-1:0]  last_shift;
        logic [TIME_W-1:0]  interval;
        int                 storm_drop;
        int                 rain_drop;
        int                 hum_rise;
        int                 ice_temp;
        logic [HUM_W-1:0]   ice_hum;
        outlook_t           pending [$];
        int                 failures;

        function new();
            foreach (press_hist[k])
            begin
                press_hist[k] = '0;
                hum_hist[k]   = '0;
            end
            filled     = 0;
            last_shift = '0;
            interval   = UPDATE_INTERVAL_RST;
            storm_drop = int'(STORM_DROP_RST);
            rain_drop  = int'(RAIN_DROP_RST);
            hum_rise   = int'(HUMIDITY_RISE_RST);
            ice_temp   = int'($signed(ICE_TEMPERATURE_RST));
            ice_hum    = ICE_HUMIDITY_RST;
            failures   = 0;
        endfunction

        static function int hpa(logic [PRESS_W-1:0] p);
            return int'(p / 100);
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_UPDATE_INTERVAL: interval   = data[TIME_W-1:0];
                REG_STORM_DROP:      storm_drop = int'(data[DROP_W-1:0]);
                REG_RAIN_DROP:       rain_drop  = int'(data[DROP_W-1:0]);
                REG_HUMIDITY_RISE:   hum_rise   = int'(data[HUM_W-1:0]);
                REG_ICE_TEMPERATURE: ice_temp   = int'($signed(data[ICE_T_W-1:0]));
                REG_ICE_HUMIDITY:    ice_hum    = data[HUM_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the forecast word for one accepted reading and queues it.
        function void note_reading(reading_t r);
            outlook_t         o;
            logic [TIME_W-1:0] elapsed;
            logic [HUM_W-1:0] level;
            int               oldest;
            int               ptrend;
            int               htrend;
            int               sp;
            int               sh;
            int               temp;
            int               adj;
            int               pd;
            int               hd;
            bit               alarm;

            elapsed = r.reading_time - last_shift;
            if (filled == 0 || elapsed >= interval)
            begin
                for (int k = 0; k < NEWEST; k++)
                begin
                    press_hist[k] = press_hist[k+1];
                    hum_hist[k]   = hum_hist[k+1];
                end
                press_hist[NEWEST] = r.pressure_pa;
                hum_hist[NEWEST]   = r.humidity;
                if (filled < HISTORY)
                    filled++;
                last_shift = r.reading_time;
            end

            o = '0;
            if (filled < 2)
            begin
                o.forecast = (r.humidity >= HUM_EARLY_RAIN) ? FC_RAIN : FC_UNKNOWN;
                pending.push_back(o);
                return;
            end

            oldest = HISTORY - int'(filled);
            if (filled >= HISTORY)
            begin
                ptrend = hpa(press_hist[NEWEST]) - hpa(press_hist[0]);
                htrend = int'(hum_hist[NEWEST]) - int'(hum_hist[0]);
            end
            else
            begin
                ptrend = hpa(r.pressure_pa) - hpa(press_hist[oldest]);
                htrend = int'(r.humidity) - int'(hum_hist[oldest]);
            end

            sp = 0;
            sh = 0;
            if (filled >= 3)
            begin
                sp = hpa(press_hist[NEWEST]) - hpa(press_hist[NEWEST-2]);
                sh = int'(hum_hist[NEWEST]) - int'(hum_hist[NEWEST-2]);
            end

            temp  = int'($signed(r.temperature));
            level = (r.hour_of_day >= 21 || r.hour_of_day <= 7) ? HUM_NIGHT_LEVEL
                                                                 : HUM_DAY_LEVEL;
            if (r.humidity >= level)
                o.forecast = (temp <= ice_temp) ? FC_SNOW : FC_RAIN;
            else if (sp <= -storm_drop)
                o.forecast = FC_SUDDEN_STORM;
            else if (sp <= -rain_drop && sh >= hum_rise)
                o.forecast = FC_SUDDEN_RAIN;
            else
            begin
                adj = hpa(r.pressure_pa) + (r.winter ? -2 : 2);
                if (ptrend > 0)
                    o.forecast = (adj >= 1020) ? FC_GOOD :
                                 (adj >= 1000) ? FC_SETTLED : FC_FINE;
                else if (ptrend < 0)
                    o.forecast = (adj >= 1010) ? FC_UNSETTLED :
                                 (adj >= 990)  ? FC_RAIN : FC_STORMY;
                else
                    o.forecast = (adj >= 1016) ? FC_FINE :
                                 (adj >= 1002) ? FC_IMPROVING : FC_CHANGEABLE;
                if (hpa(r.pressure_pa) <= int'(LOW_GUARD_HPA) &&
                    o.forecast >= FC_GOOD && o.forecast <= FC_IMPROVING)
                    o.forecast = FC_CHANGEABLE;
                if (o.forecast == FC_RAIN && temp <= ice_temp && r.humidity >= ice_hum)
                    o.forecast = FC_SNOW;
            end

            if (filled >= 3)
            begin
                if (ptrend <= -1)
                    o.timeframe = (htrend >= HUM_TREND_STEP) ? TF_IMMINENT : TF_LATER;
                else if (ptrend >= 1)
                    o.timeframe = (htrend <= -HUM_TREND_STEP) ? TF_IMMINENT : TF_LATER;
                else if (hpa(press_hist[NEWEST]) < int'(SOON_HPA) &&
                         (htrend >= HUM_TREND_STEP || r.humidity >= HUM_SOON_LEVEL))
                    o.timeframe = TF_SOON;
                else
                    o.timeframe = TF_STABLE;
            end

            alarm = 1'b0;
            for (int i = oldest; i < NEWEST && !alarm; i++)
                for (int j = i + 1; j < HISTORY && !alarm; j++)
                begin
                    pd = hpa(press_hist[j]) - hpa(press_hist[i]);
                    hd = int'(hum_hist[j]) - int'(hum_hist[i]);
                    alarm = (pd <= -storm_drop) || (pd <= -rain_drop && hd >= hum_rise);
                end
            o.radar_alert = alarm;

            pending.push_back(o);
        endfunction

        function void check_result(outlook_t got);
            outlook_t want;

            if (pending.size() == 0)
            begin
                $error("unexpected forecast word %0d/%0d/%0d",
                       got.forecast, got.timeframe, got.radar_alert);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (got.forecast !== want.forecast)
            begin
                $error("forecast: expected %0d, got %0d", want.forecast, got.forecast);
                failures++;
            end
            if (got.timeframe !== want.timeframe)
            begin
                $error("timeframe: expected %0d, got %0d", want.timeframe, got.timeframe);
                failures++;
            end
            if (got.radar_alert !== want.radar_alert)
            begin
                $error("radar_alert: expected %0d, got %0d", want.radar_alert,
                       got.radar_alert);
                failures++;
            end
        endfunction
    endclass

endpackage

### sim/tb.sv
`timescale 1ns / 100ps
module tb;
    import ptwf_pkg::*;
    import ptwf_tb_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ptwf_reading_if reading_ch ();
    ptwf_result_if  result_ch ();

    pressure_trend_weather_forecaster_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .reading (reading_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    forecast_scoreboard sb;

    // quiet: final stretch of the run, no stalls on either side
    bit quiet;

    // Weather walk: a slowly drifting pressure/humidity pair with a clock that
    // steps either past the update interval (history shifts) or short of it.
    int                walk_p;
    int                walk_dp;
    int                walk_h;
    int                walk_dh;
    logic [TIME_W-1:0] walk_t;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run guard: ends the run with FAILURE if it has not finished.
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Input side: every accepted reading goes to the predictor.
    always @(posedge clk)
    begin
        reading_t r;
        if (rst_n && reading_ch.valid && reading_ch.ready)
        begin
            r.pressure_pa  = reading_ch.pressure_pa;
            r.reading_time = reading_ch.reading_time;
            r.winter       = reading_ch.winter;
            r.temperature  = reading_ch.temperature;
            r.humidity     = reading_ch.humidity;
            r.hour_of_day  = reading_ch.hour_of_day;
            sb.note_reading(r);
        end
    end

    // Output side: every accepted word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        outlook_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.forecast    = result_ch.forecast;
            got.timeframe   = result_ch.timeframe;
            got.radar_alert = result_ch.radar_alert;
            sb.check_result(got);
        end
    end

    // Result back-pressure: stall bursts between ready runs,
    // now and then a long unbroken run. Changes only at the falling edge.
    initial
    begin
        int run;
        result_ch.ready = 1'b0;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                result_ch.ready = 1'b1;
            else if (run > 0)
                run--;
            else if (result_ch.ready)
            begin
                result_ch.ready = 1'b0;
                run = $urandom_range(0, 12);
            end
            else
            begin
                result_ch.ready = 1'b1;
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(0, 40);
            end
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_thresholds(input logic [TIME_W-1:0] iv, input int storm,
                                  input int rain, input int rise, input int ice_t,
                                  input int ice_h);
        apb_write(REG_UPDATE_INTERVAL, iv);
        apb_write(REG_STORM_DROP, 32'(storm));
        apb_write(REG_RAIN_DROP, 32'(rain));
        apb_write(REG_HUMIDITY_RISE, 32'(rise));
        apb_write(REG_ICE_TEMPERATURE, 32'(ice_t));  // sign-extended
        apb_write(REG_ICE_HUMIDITY, 32'(ice_h));
    endtask

    // Presents one word; returns right after the edge that takes it, with valid
    // still high so a following word can go back to back.
    task automatic send_reading(input reading_t r);
        @(negedge clk);
        reading_ch.pressure_pa  = r.pressure_pa;
        reading_ch.reading_time = r.reading_time;
        reading_ch.winter       = r.winter;
        reading_ch.temperature  = r.temperature;
        reading_ch.humidity     = r.humidity;
        reading_ch.hour_of_day  = r.hour_of_day;
        reading_ch.valid        = 1'b1;
        @(posedge clk);
        while (!reading_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_values(input int p, input logic [TIME_W-1:0] t, input bit w,
                               input int temp, input int hum, input int hour);
        reading_t r;
        r.pressure_pa  = p[PRESS_W-1:0];
        r.reading_time = t;
        r.winter       = w;
        r.temperature  = temp[TEMP_W-1:0];
        r.humidity     = hum[HUM_W-1:0];
        r.hour_of_day  = hour[HOUR_W-1:0];
        send_reading(r);
        walk_t = t;
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        reading_ch.valid = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Hold the sender off until every expected word is back.
    task automatic drain_results();
        @(negedge clk);
        reading_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic void new_weather();
        walk_p  = $urandom_range(94000, 106000);
        walk_dp = int'($urandom_range(0, 600)) - 300;
        walk_h  = $urandom_range(0, 10000);
        walk_dh = int'($urandom_range(0, 800)) - 400;
    endfunction

    function automatic reading_t next_weather(input bit shift);
        reading_t r;
        int       temp;

        if ($urandom_range(0, 9) == 0)
        begin
            // noise word: every field at any value its width allows
            r.pressure_pa  = PRESS_W'($urandom);
            r.reading_time = walk_t + $urandom;
            r.winter       = 1'($urandom);
            r.temperature  = TEMP_W'($urandom);
            r.humidity     = HUM_W'($urandom);
            r.hour_of_day  = HOUR_W'($urandom);
            walk_t = r.reading_time;
            return r;
        end

        if ($urandom_range(0, 15) == 0)
            walk_p -= $urandom_range(200, 1500);   // sudden fall for the radar
        walk_p += walk_dp + int'($urandom_range(0, 100)) - 50;
        walk_p = (walk_p < 0) ? 0 : (walk_p > 131071) ? 131071 : walk_p;
        walk_h += walk_dh + int'($urandom_range(0, 200)) - 100;
        walk_h = (walk_h < 0) ? 0 : (walk_h > 10000) ? 10000 : walk_h;

        if ($urandom_range(0, 3) == 0)
            temp = sb.ice_temp + int'($urandom_range(0, 200)) - 100;
        else
            temp = int'($urandom_range(0, 12500)) - 4000;

        if (shift)
            walk_t += sb.interval + $urandom_range(0, 3);
        else if (sb.interval != 0)
            walk_t += $urandom % sb.interval;

        r.pressure_pa  = walk_p[PRESS_W-1:0];
        r.reading_time = walk_t;
        r.winter       = 1'($urandom_range(0, 1));
        r.temperature  = temp[TEMP_W-1:0];
        r.humidity     = walk_h[HUM_W-1:0];
        r.hour_of_day  = HOUR_W'($urandom_range(0, 31));
        return r;
    endfunction

    task automatic run_weather(input int count);
        for (int k = 0; k < count; k++)
        begin
            if (k % 20 == 0)
                new_weather();
            if (k == count / 2 && !quiet)
                drain_results();
            send_reading(next_weather($urandom_range(0, 3) != 0));
            if (!quiet && $urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 13));
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0] iv;
        int                storm;

        sb = new();
        quiet = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        reading_ch.valid = 1'b0;
        reading_ch.pressure_pa = '0;
        reading_ch.reading_time = '0;
        reading_ch.winter = 1'b0;
        reading_ch.temperature = '0;
        reading_ch.humidity = '0;
        reading_ch.hour_of_day = '0;
        walk_t = '0;
        new_weather();

        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed words at reset thresholds. First two: a single history entry,
        // so only the early-rain humidity rule speaks.
        send_values(0, 32'd0, 1, -4000, 10000, 0);
        send_values(131071, 32'd1, 0, 8500, 7999, 23);
        // elapsed exactly the interval: shifts; 1 hPa less the winter offset
        // goes negative and lands in the lowest band
        send_values(100, 32'd900000, 1, 0, 0, 12);

        // Zero drop thresholds with two entries: the short-term storm check sees
        // zero change and still fires.
        drain_results();
        set_thresholds(32'd900000, 0, 0, 0, 200, 8000);
        send_values(100000, 32'd900100, 0, 200, 0, 8);
        send_values(100000, 32'd900200, 1, -1, 9000, 20);
        send_values(130000, 32'd900300, 0, 16383, 16383, 31);
        drain_results();
        set_thresholds(32'd900000, 3, 1, 500, 200, 8000);

        // night edges (21, 24, 7), day edges (8, 20), humidity levels on the line
        send_values(102000, 32'd2000000, 0, 201, 8800, 21);
        send_values(101900, 32'd3000000, 0, 5000, 8799, 24);
        send_values(101500, 32'd4000000, 1, -16384, 8000, 7);
        // time stamp wraps through zero
        send_values(99000, 32'hFFFF_FFFF, 0, 8500, 9500, 6);
        send_values(98000, 32'd0, 1, 200, 6500, 20);
        send_values(98000, 32'd899999, 0, -4000, 7800, 8);
        send_values(131071, 32'd1800000, 0, -4000, 0, 22);
        send_values(0, 32'd2700000, 1, 8500, 10000, 8);

        // Fill the history slowly: several non-shifting words at each depth.
        new_weather();
        while (sb.filled < HISTORY)
        begin
            send_reading(next_weather(1'b1));
            repeat (4)
            begin
                send_reading(next_weather(1'b0));
                if ($urandom_range(0, 2) == 0)
                    idle_sender($urandom_range(1, 13));
            end
        end

        // Threshold phases: both extremes, reset values, then random settings.
        for (int ph = 0; ph < 10; ph++)
        begin
            drain_results();
            quiet = (ph == 9);
            case (ph)
                0: set_thresholds(32'd0, 63, 63, 10000, -4000, 10000);
                1: set_thresholds(32'hFFFF_FFFF, 0, 0, 0, 4000, 0);
                2: set_thresholds(32'd900000, 3, 1, 500, 200, 8000);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: iv = $urandom_range(1, 5000);
                        1: iv = 32'd900000;
                        default: iv = $urandom;
                    endcase
                    storm = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                        : $urandom_range(0, 63);
                    set_thresholds(iv, storm, $urandom_range(0, 6),
                                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                                               : $urandom_range(0, 1500),
                                   ($urandom_range(0, 4) == 0) ? $urandom
                                                               : $urandom_range(0, 8000) - 4000,
                                   $urandom_range(6000, 10000));
                end
            endcase
            run_weather(82);
        end

        drain_results();
        // room for any stray word after the last expected one
        repeat (80)
            @(posedge clk);

        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
